FILE: hdl/lts_pkg.sv
package lts_pkg;

    // token codes, also bit positions in the kind mask
    localparam logic [3:0] TOK_PLUS   = 4'd0;
    localparam logic [3:0] TOK_MINUS  = 4'd1;
    localparam logic [3:0] TOK_STAR   = 4'd2;
    localparam logic [3:0] TOK_SLASH  = 4'd3;
    localparam logic [3:0] TOK_OPEN   = 4'd4;
    localparam logic [3:0] TOK_CLOSE  = 4'd5;
    localparam logic [3:0] TOK_STRING = 4'd6;
    localparam logic [3:0] TOK_CHAR   = 4'd7;
    localparam logic [3:0] TOK_INT    = 4'd8;
    localparam logic [3:0] TOK_FLOAT  = 4'd9;
    localparam logic [3:0] TOK_SPACE  = 4'd10;
    localparam logic [3:0] TOK_END    = 4'd11;

    localparam int NUM_OPS = 6;

    // item kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam int MAX_TOKEN_LEN_DEF = 65535;

    // character codes
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_U_LOWER = 8'h75;
    localparam logic [7:0] CH_U_UPPER = 8'h55;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_O       = 8'h6F;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_E_LOWER = 8'h65;
    localparam logic [7:0] CH_E_UPPER = 8'h45;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_DIG_0   = 8'h30;
    localparam logic [7:0] CH_DIG_1   = 8'h31;
    localparam logic [7:0] CH_DIG_7   = 8'h37;
    localparam logic [7:0] CH_DIG_9   = 8'h39;

    // operator characters, indexed by token code
    localparam logic [7:0] OP_CHARS [NUM_OPS] = '{
        CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN, CH_RPAREN
    };

    typedef enum logic [4:0] {
        MODE_IDLE, MODE_STR, MODE_STR_ESC, MODE_STR_HEX, MODE_CH_FIRST, MODE_CH_ESC,
        MODE_CH_HEX, MODE_CH_CLOSE, MODE_NUM_ZERO, MODE_NUM_HEX, MODE_NUM_OCT,
        MODE_NUM_BIN, MODE_NUM_INT, MODE_NUM_FRAC, MODE_NUM_EXPSIGN, MODE_NUM_EXP,
        MODE_WS
    } scan_mode_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  character;
        logic [11:0] valid_mask;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  token;
        logic        matched;
        logic [15:0] length;
        logic        last;
    } out_item_t;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= CH_DIG_0) && (c <= CH_DIG_9);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dig(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

FILE: hdl/literal_token_scanner_unit.sv
// channel   dir  handshake          payload                           notes
// s_        in   s_valid / s_ready  s_item  (kind, character, mask)   one character or end mark
// m_        out  m_valid / m_ready  m_item  (token, matched, length,  up to two results per item,
//                                           last)                     last on the final one
//
// each item is decoded against the scan state in the cycle it is accepted; its results
// are written into a four-entry result queue, which drives m_ from its head entry
// one item per cycle while items give at most one result and m_ is not stalled; an item
// with two results needs the single result port twice, which bounds the sustained rate
// s_ready is low while the queue holds more than two results, m_ stalls back up there
// reset (aresetn low, synchronous) empties the queue and returns the scanner to idle
module literal_token_scanner_unit #(
    parameter int MAX_TOKEN_LEN = lts_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lts_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output lts_pkg::out_item_t m_item
);

    localparam logic [15:0] LEN_CAP = (MAX_TOKEN_LEN < 65535) ? 16'(MAX_TOKEN_LEN) : 16'hFFFF;
    localparam int          QDEPTH  = 4;
    localparam int          QAW     = $clog2(QDEPTH);

    // scan state
    lts_pkg::scan_mode_t mode_reg, mode_next;
    logic [3:0]          esc_reg, esc_next;
    logic [3:0]          open_reg, open_next;
    logic [15:0]         len_reg, len_next;
    logic [11:0]         mask_reg, mask_next;

    // result queue
    lts_pkg::out_item_t  queue_reg [QDEPTH];
    logic [QAW-1:0]      head_reg, head_next;
    logic [QAW-1:0]      tail_reg, tail_next;
    logic [QAW:0]        count_reg, count_next;

    logic                s_fire;
    logic                m_fire;
    logic [7:0]          c;
    logic [11:0]         msk;
    logic                hex_c;
    logic                dig_c;
    logic                ws_c;
    logic                op_hit;
    logic [3:0]          op_code;
    logic                st_str;
    logic                st_chr;
    logic                st_num;
    logic                st_ws;

    lts_pkg::scan_mode_t eff_mode;
    logic                grow;
    logic                do_close;
    logic                restart;
    logic [15:0]         len_grown;
    logic [15:0]         mask_wide;
    logic                close_m;

    lts_pkg::out_item_t  res0;
    lts_pkg::out_item_t  res1;
    logic [1:0]          res_cnt;
    logic [1:0]          push;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;
    assign c      = s_item.character;
    assign msk    = s_item.valid_mask;
    assign hex_c  = lts_pkg::is_hex(c);
    assign dig_c  = lts_pkg::is_dig(c);
    assign ws_c   = lts_pkg::is_ws(c);

    // start-of-token decode under this item's mask
    always_comb begin
        op_hit  = 1'b0;
        op_code = lts_pkg::TOK_PLUS;
        for (int t = lts_pkg::NUM_OPS - 1; t >= 0; t--) begin
            if (msk[t] && (c == lts_pkg::OP_CHARS[t])) begin
                op_hit  = 1'b1;
                op_code = 4'(t);
            end
        end
        st_str = msk[lts_pkg::TOK_STRING] && (c == lts_pkg::CH_DQUOTE);
        st_chr = msk[lts_pkg::TOK_CHAR] && (c == lts_pkg::CH_SQUOTE);
        st_num = (msk[lts_pkg::TOK_INT] || msk[lts_pkg::TOK_FLOAT])
                 && (dig_c || (c == lts_pkg::CH_PLUS) || (c == lts_pkg::CH_MINUS));
        st_ws  = msk[lts_pkg::TOK_SPACE] && ws_c;
    end

    // next scan state
    always_comb begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        open_next = open_reg;
        mask_next = mask_reg;
        eff_mode  = mode_reg;
        grow      = 1'b0;
        do_close  = 1'b0;
        restart   = 1'b0;

        // a cut-short hex escape or a zero without prefix falls through to the plain mode
        if ((mode_reg == lts_pkg::MODE_STR_HEX) && !hex_c) begin
            eff_mode = lts_pkg::MODE_STR;
            esc_next = 4'd0;
        end else if ((mode_reg == lts_pkg::MODE_CH_HEX) && !hex_c) begin
            eff_mode = lts_pkg::MODE_CH_CLOSE;
            esc_next = 4'd0;
        end else if ((mode_reg == lts_pkg::MODE_NUM_ZERO) && (c != lts_pkg::CH_X)
                     && (c != lts_pkg::CH_O) && (c != lts_pkg::CH_B)) begin
            eff_mode = lts_pkg::MODE_NUM_INT;
        end
        mode_next = eff_mode;

        if (s_item.kind == lts_pkg::KIND_END) begin
            do_close = (mode_reg != lts_pkg::MODE_IDLE);
        end else begin
            unique case (eff_mode)
                lts_pkg::MODE_IDLE: begin
                    restart = 1'b1;
                end
                lts_pkg::MODE_STR: begin
                    grow = 1'b1;
                    if (c == lts_pkg::CH_DQUOTE) begin
                        do_close = 1'b1;
                    end else if (c == lts_pkg::CH_BSLASH) begin
                        mode_next = lts_pkg::MODE_STR_ESC;
                    end
                end
                lts_pkg::MODE_STR_ESC, lts_pkg::MODE_CH_ESC: begin
                    grow = 1'b1;
                    if (c == lts_pkg::CH_U_LOWER || c == lts_pkg::CH_U_UPPER) begin
                        esc_next  = (c == lts_pkg::CH_U_LOWER) ? 4'd4 : 4'd8;
                        mode_next = (eff_mode == lts_pkg::MODE_STR_ESC) ?
                                    lts_pkg::MODE_STR_HEX : lts_pkg::MODE_CH_HEX;
                    end else begin
                        mode_next = (eff_mode == lts_pkg::MODE_STR_ESC) ?
                                    lts_pkg::MODE_STR : lts_pkg::MODE_CH_CLOSE;
                    end
                end
                lts_pkg::MODE_STR_HEX, lts_pkg::MODE_CH_HEX: begin
                    grow = 1'b1;
                    if (esc_reg <= 4'd1) begin
                        esc_next  = 4'd0;
                        mode_next = (eff_mode == lts_pkg::MODE_STR_HEX) ?
                                    lts_pkg::MODE_STR : lts_pkg::MODE_CH_CLOSE;
                    end else begin
                        esc_next = esc_reg - 4'd1;
                    end
                end
                lts_pkg::MODE_CH_FIRST: begin
                    grow = 1'b1;
                    if (c == lts_pkg::CH_SQUOTE) begin
                        do_close = 1'b1;
                    end else begin
                        mode_next = (c == lts_pkg::CH_BSLASH) ?
                                    lts_pkg::MODE_CH_ESC : lts_pkg::MODE_CH_CLOSE;
                    end
                end
                lts_pkg::MODE_CH_CLOSE: begin
                    do_close = 1'b1;
                    if (c == lts_pkg::CH_SQUOTE) begin
                        grow = 1'b1;
                    end else begin
                        restart = 1'b1;
                    end
                end
                lts_pkg::MODE_NUM_ZERO: begin
                    grow = 1'b1;
                    if (c == lts_pkg::CH_X) begin
                        mode_next = lts_pkg::MODE_NUM_HEX;
                    end else if (c == lts_pkg::CH_O) begin
                        mode_next = lts_pkg::MODE_NUM_OCT;
                    end else begin
                        mode_next = lts_pkg::MODE_NUM_BIN;
                    end
                end
                lts_pkg::MODE_NUM_HEX: begin
                    grow     = hex_c;
                    do_close = !hex_c;
                    restart  = !hex_c;
                end
                lts_pkg::MODE_NUM_OCT: begin
                    grow     = (c >= lts_pkg::CH_DIG_0) && (c <= lts_pkg::CH_DIG_7);
                    do_close = !grow;
                    restart  = !grow;
                end
                lts_pkg::MODE_NUM_BIN: begin
                    grow     = (c == lts_pkg::CH_DIG_0) || (c == lts_pkg::CH_DIG_1);
                    do_close = !grow;
                    restart  = !grow;
                end
                lts_pkg::MODE_NUM_INT: begin
                    if (dig_c) begin
                        grow = 1'b1;
                    end else if (mask_reg[lts_pkg::TOK_FLOAT] && (c == lts_pkg::CH_POINT)) begin
                        grow      = 1'b1;
                        open_next = lts_pkg::TOK_FLOAT;
                        mode_next = lts_pkg::MODE_NUM_FRAC;
                    end else if (mask_reg[lts_pkg::TOK_FLOAT]
                                 && (c == lts_pkg::CH_E_LOWER || c == lts_pkg::CH_E_UPPER)) begin
                        grow      = 1'b1;
                        open_next = lts_pkg::TOK_FLOAT;
                        mode_next = lts_pkg::MODE_NUM_EXPSIGN;
                    end else begin
                        do_close = 1'b1;
                        restart  = 1'b1;
                    end
                end
                lts_pkg::MODE_NUM_FRAC: begin
                    if (dig_c) begin
                        grow = 1'b1;
                    end else if (c == lts_pkg::CH_E_LOWER || c == lts_pkg::CH_E_UPPER) begin
                        grow      = 1'b1;
                        mode_next = lts_pkg::MODE_NUM_EXPSIGN;
                    end else begin
                        do_close = 1'b1;
                        restart  = 1'b1;
                    end
                end
                lts_pkg::MODE_NUM_EXPSIGN: begin
                    if (dig_c || (c == lts_pkg::CH_PLUS) || (c == lts_pkg::CH_MINUS)) begin
                        grow      = 1'b1;
                        mode_next = lts_pkg::MODE_NUM_EXP;
                    end else begin
                        do_close = 1'b1;
                        restart  = 1'b1;
                    end
                end
                lts_pkg::MODE_NUM_EXP: begin
                    grow     = dig_c;
                    do_close = !dig_c;
                    restart  = !dig_c;
                end
                lts_pkg::MODE_WS: begin
                    grow     = ws_c;
                    do_close = !ws_c;
                    restart  = !ws_c;
                end
                default: begin
                    restart   = 1'b1;
                    mode_next = lts_pkg::MODE_IDLE;
                end
            endcase
        end

        // saturating length count
        len_grown = (grow && (len_reg < LEN_CAP)) ? len_reg + 16'd1 : len_reg;
        len_next  = len_grown;

        if (do_close) begin
            mode_next = lts_pkg::MODE_IDLE;
            open_next = 4'd0;
            len_next  = 16'd0;
            esc_next  = 4'd0;
        end

        // a non-operator char that ended the token, or found the scanner idle, can open a new one
        if ((s_item.kind == lts_pkg::KIND_CHAR) && restart && !op_hit) begin
            mask_next = msk;
            len_next  = 16'd1;
            esc_next  = 4'd0;
            if (st_str) begin
                open_next = lts_pkg::TOK_STRING;
                mode_next = lts_pkg::MODE_STR;
            end else if (st_chr) begin
                open_next = lts_pkg::TOK_CHAR;
                mode_next = lts_pkg::MODE_CH_FIRST;
            end else if (st_num) begin
                open_next = lts_pkg::TOK_INT;
                mode_next = (msk[lts_pkg::TOK_INT] && (c == lts_pkg::CH_DIG_0)) ?
                            lts_pkg::MODE_NUM_ZERO : lts_pkg::MODE_NUM_INT;
            end else if (st_ws) begin
                open_next = lts_pkg::TOK_SPACE;
                mode_next = lts_pkg::MODE_WS;
            end else begin
                len_next = 16'd0;
            end
        end
    end

    // result formation
    always_comb begin
        lts_pkg::out_item_t start_res;
        logic               start_valid;

        mask_wide = {4'd0, mask_reg};
        close_m   = mask_wide[open_reg];

        start_res   = '0;
        start_valid = 1'b0;
        if (s_item.kind == lts_pkg::KIND_END) begin
            start_valid       = 1'b1;
            start_res.matched = msk[lts_pkg::TOK_END];
            start_res.token   = msk[lts_pkg::TOK_END] ? lts_pkg::TOK_END : 4'd0;
            start_res.length  = 16'd0;
        end else if (restart && op_hit) begin
            start_valid       = 1'b1;
            start_res.token   = op_code;
            start_res.matched = 1'b1;
            start_res.length  = 16'd1;
        end else if (restart && !(st_str || st_chr || st_num || st_ws)) begin
            start_valid       = 1'b1;
            start_res.token   = 4'd0;
            start_res.matched = 1'b0;
            start_res.length  = 16'd1;
        end

        res0 = '0;
        res1 = '0;
        if (do_close) begin
            res0.token   = close_m ? open_reg : 4'd0;
            res0.matched = close_m;
            res0.length  = len_grown;
            res0.last    = !start_valid;
            res1         = start_res;
            res1.last    = 1'b1;
            res_cnt      = start_valid ? 2'd2 : 2'd1;
        end else begin
            res0      = start_res;
            res0.last = 1'b1;
            res_cnt   = start_valid ? 2'd1 : 2'd0;
        end
    end

    // queue pointers
    always_comb begin
        push       = s_fire ? res_cnt : 2'd0;
        head_next  = m_fire ? head_reg + 1'b1 : head_reg;
        tail_next  = tail_reg + QAW'(push);
        count_next = count_reg + (QAW+1)'(push) - (QAW+1)'(m_fire);
    end

    assign s_ready = (count_reg <= (QAW+1)'(QDEPTH - 2));
    assign m_valid = (count_reg != '0);
    assign m_item  = queue_reg[head_reg];

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= lts_pkg::MODE_IDLE;
            esc_reg   <= 4'd0;
            open_reg  <= 4'd0;
            len_reg   <= 16'd0;
            mask_reg  <= 12'd0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (s_fire) begin
                mode_reg <= mode_next;
                esc_reg  <= esc_next;
                open_reg <= open_next;
                len_reg  <= len_next;
                mask_reg <= mask_next;
            end
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push != 2'd0) begin
            queue_reg[tail_reg] <= res0;
        end
        if (push == 2'd2) begin
            queue_reg[tail_reg + 1'b1] <= res1;
        end
    end

    // an end item always leaves the scanner idle
    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_item.kind == lts_pkg::KIND_END)) |=> (mode_reg == lts_pkg::MODE_IDLE))
        else $error("scanner not idle after end item");

    // idle carries no leftover token state
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == lts_pkg::MODE_IDLE) |-> (esc_reg == 4'd0 && open_reg == 4'd0
                                             && len_reg == 16'd0))
        else $error("idle scanner holds token state");

    // queue never overfills
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QAW+1)'(QDEPTH))
        else $error("result queue overflow");

    // the length never passes its cap
    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_CAP)
        else $error("token length beyond cap");

endmodule
